[hdl/lapbtr_pkg.sv]
// Shared types, codes and AX.25 control constants for the LAPB timer recovery unit.
// Used by every module of the block; depends on nothing.
package lapbtr_pkg;

	// AX.25 control field values
	localparam logic [2:0] MMASK = 3'd7;
	localparam logic [7:0] PF    = 8'h10;
	localparam logic [7:0] SABM  = 8'h2F;
	localparam logic [7:0] DISC  = 8'h43;
	localparam logic [7:0] DM    = 8'h0F;
	localparam logic [7:0] RR    = 8'h01;
	localparam logic [7:0] RNR   = 8'h05;

	// link states
	localparam logic [2:0] ST_DISC  = 3'd0;
	localparam logic [2:0] ST_SETUP = 3'd1;
	localparam logic [2:0] ST_DPEND = 3'd2;
	localparam logic [2:0] ST_CONN  = 3'd3;
	localparam logic [2:0] ST_RECOV = 3'd4;

	// timer events
	localparam logic ACT_T1 = 1'b0;
	localparam logic ACT_T3 = 1'b1;

	// frame kinds
	localparam logic [1:0] FK_NONE = 2'd0;
	localparam logic [1:0] FK_CTRL = 2'd1;
	localparam logic [1:0] FK_IFRM = 2'd2;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRIES    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_POLL_THRESHOLD = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RECEIVE_WINDOW = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_OLD_PROTOCOL   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF_LIMIT  = 3'd4;
	localparam int CFG_DATA_W = 32;

	typedef struct packed {
		logic [7:0]  max_retries;
		logic [15:0] poll_threshold;
		logic [15:0] receive_window;
		logic        old_protocol;
		logic [30:0] backoff_limit;
	} cfg_t;

	typedef struct packed {
		logic        action;
		logic [2:0]  link_state;
		logic [7:0]  retry_count;
		logic [31:0] t1_duration;
		logic        txq_nonempty;
		logic [15:0] oldest_frame_len;
		logic [15:0] rxq_len;
		logic [2:0]  send_seq;
		logic [2:0]  unacked_count;
		logic [2:0]  recv_seq;
	} item_t;

	typedef struct packed {
		logic [2:0]  next_state;
		logic [7:0]  next_retries;
		logic [31:0] next_t1_duration;
		logic [1:0]  frame_kind;
		logic        is_command;
		logic [7:0]  control_byte;
		logic        flush_txq;
		logic        timed_out;
		logic        set_retransmit;
		logic        restart_t1;
		logic        poll_sent;
	} result_t;

endpackage

[hdl/lapbtr_cfg_regs.sv]
// Configuration register file of the LAPB timer recovery unit.
// Depends on lapbtr_pkg for the register indexes and cfg_t.
module lapbtr_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [lapbtr_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [lapbtr_pkg::CFG_DATA_W-1:0] wr_data,
	output lapbtr_pkg::cfg_t              cfg
);
	import lapbtr_pkg::*;

	cfg_t cfg_q;

	// write one register per transfer; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_retries    <= 8'd10;
			cfg_q.poll_threshold <= 16'd128;
			cfg_q.receive_window <= 16'd2048;
			cfg_q.old_protocol   <= 1'b0;
			cfg_q.backoff_limit  <= 31'd30;
		end else if (wr_en) begin
			case (wr_index)
				CFG_MAX_RETRIES:    cfg_q.max_retries    <= wr_data[7:0];
				CFG_POLL_THRESHOLD: cfg_q.poll_threshold <= wr_data[15:0];
				CFG_RECEIVE_WINDOW: cfg_q.receive_window <= wr_data[15:0];
				CFG_OLD_PROTOCOL:   cfg_q.old_protocol   <= wr_data[0];
				CFG_BACKOFF_LIMIT:  cfg_q.backoff_limit  <= wr_data[30:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[hdl/lapbtr_decide.sv]
// Combinational decision logic: one timer event in, one recovery result out.
// Depends on lapbtr_pkg for codes, constants and the item/result structs.
module lapbtr_decide (
	input  lapbtr_pkg::cfg_t    cfg,
	input  lapbtr_pkg::item_t   item,
	output lapbtr_pkg::result_t res
);
	import lapbtr_pkg::*;

	logic [7:0]  rt_inc;
	logic [30:0] pow;
	logic        backoff;
	logic [31:0] t1_dbl;
	logic        give_up;
	logic        use_ifrm;
	logic [2:0]  ns;
	logic [7:0]  poll_ctrl;
	logic [1:0]  poll_kind;

	// saturating retry increment and T1 backoff
	assign rt_inc  = (item.retry_count != 8'hFF) ? item.retry_count + 8'd1 : item.retry_count;
	assign pow     = 31'd1 << rt_inc[4:0];
	assign backoff = (rt_inc < 8'd31) && (pow < cfg.backoff_limit);
	assign t1_dbl  = item.t1_duration[31] ? 32'hFFFF_FFFF : {item.t1_duration[30:0], 1'b0};
	assign give_up = (cfg.max_retries != 8'd0) && (rt_inc > cfg.max_retries);

	// poll frame: oldest I-frame again, or RR/RNR
	assign use_ifrm  = item.txq_nonempty &&
		((item.oldest_frame_len < cfg.poll_threshold) || cfg.old_protocol);
	assign ns        = (item.send_seq - item.unacked_count) & MMASK;
	assign poll_kind = use_ifrm ? FK_IFRM : FK_CTRL;
	assign poll_ctrl = use_ifrm ? ({item.recv_seq, 1'b0, ns, 1'b0} | PF)
		: ((item.rxq_len >= cfg.receive_window) ? (RNR | PF) : (RR | PF));

	always_comb begin
		res = '0;
		res.next_state       = item.link_state;
		res.next_retries     = item.retry_count;
		res.next_t1_duration = item.t1_duration;
		if (item.action == ACT_T1) begin
			res.set_retransmit = 1'b1;
			res.next_retries   = rt_inc;
			if (backoff) begin
				res.next_t1_duration = t1_dbl;
			end
			case (item.link_state)
				ST_SETUP, ST_DPEND: begin
					if (give_up) begin
						res.flush_txq  = (item.link_state == ST_SETUP);
						res.timed_out  = 1'b1;
						res.next_state = ST_DISC;
					end else begin
						res.frame_kind   = FK_CTRL;
						res.is_command   = 1'b1;
						res.control_byte = ((item.link_state == ST_SETUP) ? SABM : DISC) | PF;
						res.restart_t1   = 1'b1;
					end
				end
				ST_CONN, ST_RECOV: begin
					if (give_up) begin
						res.frame_kind   = FK_CTRL;
						res.control_byte = DM | PF;
						res.flush_txq    = 1'b1;
						res.timed_out    = 1'b1;
						res.next_state   = ST_DISC;
					end else begin
						res.frame_kind   = poll_kind;
						res.is_command   = 1'b1;
						res.control_byte = poll_ctrl;
						res.restart_t1   = 1'b1;
						res.poll_sent    = 1'b1;
						res.next_state   = ST_RECOV;
					end
				end
				default: ;
			endcase
		end else if (!cfg.old_protocol && item.link_state == ST_CONN) begin
			// idle poll from the connected state
			res.next_retries = 8'd0;
			res.frame_kind   = poll_kind;
			res.is_command   = 1'b1;
			res.control_byte = poll_ctrl;
			res.restart_t1   = 1'b1;
			res.poll_sent    = 1'b1;
			res.next_state   = ST_RECOV;
		end
	end

endmodule

[hdl/lapb_timer_recovery_unit.sv]
// Top level of the LAPB timer recovery unit: input register, decision logic,
// result register and configuration port. Depends on lapbtr_pkg, lapbtr_cfg_regs, lapbtr_decide.
//
// channel  | handshake                 | payload
// ---------+---------------------------+------------------------------------------
// event in | start & !busy             | action .. recv_seq
// result   | done (one-cycle strobe)   | next_state .. poll_sent
// config   | cfg_valid & cfg_ready     | cfg_index, cfg_data
//
// One event per cycle is accepted; busy stays low. After the accepting edge the event
// is held in the input register, and its result is then captured in the result
// register. The receiver cannot stall, so results are never held back.
// Reset clears the valid flags and loads the register defaults; payload is not reset.
// cfg_ready is always high; one register is written per transfer.
module lapb_timer_recovery_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              action,
	input  logic [2:0]                        link_state,
	input  logic [7:0]                        retry_count,
	input  logic [31:0]                       t1_duration,
	input  logic                              txq_nonempty,
	input  logic [15:0]                       oldest_frame_len,
	input  logic [15:0]                       rxq_len,
	input  logic [2:0]                        send_seq,
	input  logic [2:0]                        unacked_count,
	input  logic [2:0]                        recv_seq,
	output logic                              done,
	output logic [2:0]                        next_state,
	output logic [7:0]                        next_retries,
	output logic [31:0]                       next_t1_duration,
	output logic [1:0]                        frame_kind,
	output logic                              is_command,
	output logic [7:0]                        control_byte,
	output logic                              flush_txq,
	output logic                              timed_out,
	output logic                              set_retransmit,
	output logic                              restart_t1,
	output logic                              poll_sent,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [lapbtr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lapbtr_pkg::CFG_DATA_W-1:0] cfg_data
);
	import lapbtr_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_comb;
	result_t res_s2;
	logic    valid_s2;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	lapbtr_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// capture the event on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start & ~busy) begin
			item_s1.action           <= action;
			item_s1.link_state       <= link_state;
			item_s1.retry_count      <= retry_count;
			item_s1.t1_duration      <= t1_duration;
			item_s1.txq_nonempty     <= txq_nonempty;
			item_s1.oldest_frame_len <= oldest_frame_len;
			item_s1.rxq_len          <= rxq_len;
			item_s1.send_seq         <= send_seq;
			item_s1.unacked_count    <= unacked_count;
			item_s1.recv_seq         <= recv_seq;
		end
	end

	lapbtr_decide u_decide (
		.cfg  (cfg),
		.item (item_s1),
		.res  (res_comb)
	);

	// register the result and the strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			res_s2 <= res_comb;
		end
	end

	assign done             = valid_s2;
	assign next_state       = res_s2.next_state;
	assign next_retries     = res_s2.next_retries;
	assign next_t1_duration = res_s2.next_t1_duration;
	assign frame_kind       = res_s2.frame_kind;
	assign is_command       = res_s2.is_command;
	assign control_byte     = res_s2.control_byte;
	assign flush_txq        = res_s2.flush_txq;
	assign timed_out        = res_s2.timed_out;
	assign set_retransmit   = res_s2.set_retransmit;
	assign restart_t1       = res_s2.restart_t1;
	assign poll_sent        = res_s2.poll_sent;

	// every accepted event yields exactly one strobe, after the input and result registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ##1 done)
		else $error("result strobe missing after accepted event");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(valid_s1))
		else $error("result strobe without a captured event");

	a_timeout_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(done && timed_out) |-> (next_state == ST_DISC && !restart_t1 && !poll_sent))
		else $error("timeout result does not drop the link");

	a_poll_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(done && poll_sent) |-> (restart_t1 && is_command && next_state == ST_RECOV
			&& frame_kind != FK_NONE))
		else $error("poll result inconsistent");

endmodule
